[hw/rtl/lrgc_pkg.sv]
package lrgc_pkg;

  localparam int INDEX_BITS    = 17;
  localparam int RADIUS_BITS   = 18;
  localparam int HEIGHT_BITS   = 16;
  localparam int CFG_DATA_BITS = 18;

  typedef enum logic [1:0] {
    VERDICT_REMOVED    = 2'd0,
    VERDICT_GROUND     = 2'd1,
    VERDICT_NOT_GROUND = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    REG_MOUNT_HEIGHT      = 3'd0,
    REG_TAN_GENERAL_SLOPE = 3'd1,
    REG_TAN_LOCAL_SLOPE   = 3'd2,
    REG_RADIAL_STEP       = 3'd3,
    REG_MIN_HEIGHT_LIMIT  = 3'd4,
    REG_CLIP_HEIGHT       = 3'd5,
    REG_MIN_DISTANCE      = 3'd6,
    REG_RECLASS_DISTANCE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [RADIUS_BITS-1:0]        radius_mm;
    logic signed [HEIGHT_BITS-1:0] height_mm;
    logic                          sector_start;
    logic [INDEX_BITS-1:0]         point_index;
  } point_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] point_index_out;
    verdict_t              verdict;
  } result_t;

  typedef struct packed {
    logic [12:0]                   mount_height;
    logic [15:0]                   tan_general_slope;
    logic [15:0]                   tan_local_slope;
    logic [15:0]                   radial_step;
    logic [15:0]                   min_height_limit;
    logic signed [HEIGHT_BITS-1:0] clip_height;
    logic [RADIUS_BITS-1:0]        min_distance;
    logic [RADIUS_BITS-1:0]        reclass_distance;
  } cfg_t;

  typedef struct packed {
    logic [RADIUS_BITS-1:0]        radius;
    logic signed [HEIGHT_BITS-1:0] height;
    logic                          ground;
  } hist_t;

  localparam cfg_t CFG_RESET = '{
    mount_height:      13'd2680,
    tan_general_slope: 16'd3434,
    tan_local_slope:   16'd5734,
    radial_step:       16'd10,
    min_height_limit:  16'd350,
    clip_height:       16'sd300,
    min_distance:      18'd1850,
    reclass_distance:  18'd175
  };

  // History at sector start: height at minus the mount height, no radius, not ground.
  function automatic hist_t hist_clear(input logic [12:0] mount_height);
    hist_t h;
    h.radius = '0;
    h.height = HEIGHT_BITS'(-$signed({3'b000, mount_height}));
    h.ground = 1'b0;
    return h;
  endfunction

endpackage

[hw/rtl/lidar_ray_ground_classifier.sv]
// Channel | Signals                        | Direction | Transfer when
// in      | in_valid, in_stall, in_data    | in        | in_valid && !in_stall
// out     | out_valid, out_stall, out_data | out       | out_valid && !out_stall
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in | cfg_valid && cfg_ready
//
// One point per cycle unless out_stall holds; each point passes in_reg, then out_reg.
// The limit is the history loop: radius, height and ground mark feed the next point.
// Reset (rst, synchronous) empties both stages, restores register defaults and clears history.
// out_stall holds the output register; the input register backs up behind it and in_stall rises.
module lidar_ray_ground_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lrgc_pkg::point_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lrgc_pkg::result_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  lrgc_pkg::cfg_reg_t                   cfg_index,
  input  logic [lrgc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import lrgc_pkg::*;

  cfg_t     cfg;
  hist_t    hist;
  hist_t    hist_next;
  point_t   in_reg;
  logic     in_vld;
  result_t  out_reg;
  logic     out_vld;
  verdict_t verdict;
  logic     adv;

  lrgc_classify u_classify (
    .point     (in_reg),
    .hist      (hist),
    .cfg       (cfg),
    .verdict   (verdict),
    .hist_next (hist_next)
  );

  assign adv       = in_vld && (!out_vld || !out_stall);
  assign in_stall  = in_vld && !adv;
  assign out_valid = out_vld;
  assign out_data  = out_reg;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MOUNT_HEIGHT:      cfg.mount_height      <= cfg_data[12:0];
        REG_TAN_GENERAL_SLOPE: cfg.tan_general_slope <= cfg_data[15:0];
        REG_TAN_LOCAL_SLOPE:   cfg.tan_local_slope   <= cfg_data[15:0];
        REG_RADIAL_STEP:       cfg.radial_step       <= cfg_data[15:0];
        REG_MIN_HEIGHT_LIMIT:  cfg.min_height_limit  <= cfg_data[15:0];
        REG_CLIP_HEIGHT:       cfg.clip_height       <= $signed(cfg_data[15:0]);
        REG_MIN_DISTANCE:      cfg.min_distance      <= cfg_data[17:0];
        REG_RECLASS_DISTANCE:  cfg.reclass_distance  <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      hist    <= hist_clear(CFG_RESET.mount_height);
    end else begin
      if (!in_stall) begin
        in_vld <= in_valid;
      end
      if (adv) begin
        out_vld <= 1'b1;
        hist    <= hist_next;
      end else if (!out_stall) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg <= in_data;
    end
    if (adv) begin
      out_reg.point_index_out <= in_reg.point_index;
      out_reg.verdict         <= verdict;
    end
  end

endmodule

[hw/rtl/lrgc_classify.sv]
module lrgc_classify (
  input  lrgc_pkg::point_t   point,
  input  lrgc_pkg::hist_t    hist,
  input  lrgc_pkg::cfg_t     cfg,
  output lrgc_pkg::verdict_t verdict,
  output lrgc_pkg::hist_t    hist_next
);
  import lrgc_pkg::*;

  hist_t              prev;
  logic               removed;
  logic signed [18:0] gap;
  logic signed [19:0] gap_x;
  logic signed [35:0] thr_raw;
  logic signed [35:0] thr;
  logic signed [35:0] gthr;
  logic signed [35:0] minq;
  logic signed [16:0] dl;
  logic signed [16:0] ds;
  logic signed [37:0] dlq;
  logic signed [37:0] dsq;
  logic               in_local;
  logic               in_general;
  logic               in_reclass;
  logic               ground;

  function automatic logic in_window(input logic signed [37:0] dq,
                                     input logic signed [35:0] t);
    logic signed [37:0] tx;
    tx = {{2{t[35]}}, t};
    return (dq <= tx) && (dq >= -tx);
  endfunction

  always_comb begin
    prev    = point.sector_start ? hist_clear(cfg.mount_height) : hist;
    removed = (point.height_mm > cfg.clip_height) || (point.radius_mm < cfg.min_distance);

    gap     = $signed({1'b0, point.radius_mm}) - $signed({1'b0, prev.radius});
    gap_x   = {gap[18], gap};
    thr_raw = $signed({1'b0, cfg.tan_local_slope}) * gap;
    gthr    = $signed({1'b0, cfg.tan_general_slope}) * $signed({1'b0, point.radius_mm});
    minq    = $signed({4'b0000, cfg.min_height_limit, 16'h0000});

    // Raise the local threshold to the floor once the step is wide enough.
    if (gap_x > $signed({4'b0000, cfg.radial_step}) && thr_raw < minq) begin
      thr = minq;
    end else begin
      thr = thr_raw;
    end

    dl  = {point.height_mm[15], point.height_mm} - {prev.height[15], prev.height};
    ds  = {point.height_mm[15], point.height_mm} + $signed({4'b0000, cfg.mount_height});
    dlq = {{5{dl[16]}}, dl, 16'h0000};
    dsq = {{5{ds[16]}}, ds, 16'h0000};

    in_local   = in_window(dlq, thr);
    in_general = in_window(dsq, gthr);
    in_reclass = (gap_x > $signed({2'b00, cfg.reclass_distance})) && in_window(dsq, thr);

    if (in_local) begin
      ground = prev.ground || in_general;
    end else begin
      ground = in_reclass;
    end

    if (removed) begin
      verdict   = VERDICT_REMOVED;
      hist_next = prev;
    end else begin
      verdict          = ground ? VERDICT_GROUND : VERDICT_NOT_GROUND;
      hist_next.radius = point.radius_mm;
      hist_next.height = point.height_mm;
      hist_next.ground = ground;
    end
  end

endmodule

[hw/rtl/lrgc_checker.sv]
module lrgc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lrgc_pkg::result_t   out_data,
  input logic                cfg_valid,
  input logic                cfg_ready
);
  import lrgc_pkg::*;

  // Input backs up only behind a held result.
  a_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.verdict == VERDICT_REMOVED ||
                   out_data.verdict == VERDICT_GROUND ||
                   out_data.verdict == VERDICT_NOT_GROUND))
    else $error("undefined verdict code");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule

bind lidar_ray_ground_classifier lrgc_checker u_lrgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
